@@ design/abwm_pkg.sv @@
// ----------------------------------------------------------------------------
// Burst write master package
// Shared sizes, function and status codes, and the item, result and
// configuration records that pass between the modules of the block.
// ----------------------------------------------------------------------------
package abwm_pkg;

  localparam int BUS_BYTES_N   = 8;
  localparam int DATA_W        = 8 * BUS_BYTES_N;
  localparam int OFF_W         = $clog2(BUS_BYTES_N);
  localparam int PAGE_BYTES    = 4096;
  localparam int PAGE_W        = $clog2(PAGE_BYTES);
  localparam int PAGE_LINES_W  = PAGE_W - OFF_W + 1;
  localparam int LEN_WIDTH     = 8;
  localparam int BEATS_W       = LEN_WIDTH + 1;
  localparam int ADDR_WIDTH    = 32;
  localparam int COUNT_WIDTH   = 21;
  localparam int LINES_W       = COUNT_WIDTH - OFF_W;
  localparam int ID_W          = 4;
  localparam int RESP_W        = 2;
  localparam int FUNC_W        = 2;
  localparam int CFG_DATA_W    = 9;
  localparam int CFG_IDX_W     = 1;

  localparam logic [COUNT_WIDTH-1:0]  MAX_COUNT     = COUNT_WIDTH'(2 ** (COUNT_WIDTH - 1));
  localparam logic [BEATS_W-1:0]      MAX_BEATS     = BEATS_W'(2 ** LEN_WIDTH);
  localparam logic [PAGE_LINES_W-1:0] PAGE_LINES    = PAGE_LINES_W'(PAGE_BYTES / BUS_BYTES_N);
  localparam logic [CFG_DATA_W-1:0]   RESET_BEAT_LIMIT = CFG_DATA_W'(256);
  localparam logic [ID_W-1:0]         RESET_ID      = ID_W'(4);

  // Input item kinds.
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BEAT  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESP  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BEAT_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_XFER_ID    = 1'd1;

  localparam logic [RESP_W-1:0] RESP_OKAY = 2'd0;

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 120;

  typedef enum logic [1:0] {
    ST_BEAT    = 2'd0,
    ST_DONE    = 2'd1,
    ST_ABORT   = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef struct packed {
    logic [FUNC_W-1:0]      func;
    logic [ADDR_WIDTH-1:0]  start_address;
    logic [COUNT_WIDTH-1:0] xfer_bytes;
    logic [DATA_W-1:0]      source_data;
    logic [RESP_W-1:0]      response;
  } item_t;

  typedef struct packed {
    logic                   addr_valid;
    logic [ADDR_WIDTH-1:0]  burst_address;
    logic [LEN_WIDTH-1:0]   burst_len;
    logic [ID_W-1:0]        burst_id;
    logic [DATA_W-1:0]      beat_data;
    logic [BUS_BYTES_N-1:0] beat_strobe;
    logic                   beat_last;
    status_e                status;
    logic [RESP_W-1:0]      error_response;
  } result_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] beat_limit;
    logic [ID_W-1:0]       transfer_id;
  } cfg_t;

endpackage

@@ design/axi_burst_write_master.sv @@
// ----------------------------------------------------------------------------
// Burst write master
// Splits a byte-addressed transfer into aligned incrementing bursts.
// ----------------------------------------------------------------------------
// Usage: the slave stream carries commands selected by s_axis_tuser: a start
// command (address and byte count), one beat transaction per bus word with the
// next packed source word, and the write response after each burst. The
// master stream returns one result per beat (data, strobes, and burst address,
// length and id on the first beat of each burst, tlast on its final beat) and
// a status result for a finished, aborted or ignored transaction. A start and
// an okay response that leaves lines to send return nothing.
// A transaction lands in the input register, and the engine writes its result
// into the output register once that register can take it.
// Throughput is one transaction per cycle while the receiver takes results, set
// by the single pass from the input register to the output register.
// Reset clears the transfer state, empties both registers and loads the
// configuration defaults (256 beats per burst, id 4). When the receiver stalls
// the result holds in the output register, one more transaction waits in the
// input register, and s_axis_tready then drops until the output drains.
// Configuration writes take effect at once and belong between transfers.
// ----------------------------------------------------------------------------
module axi_burst_write_master
  import abwm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // start_address, byte_count, source_data, response, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // func
  input  logic [FUNC_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // addr_valid, burst_address, burst_len, burst_id, beat_data, beat_strobe,
  // error_response, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  // status
  output logic [1:0]            m_axis_tuser
);

  cfg_t    cfg_q;
  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    fire;
  logic    has_res;
  result_t res;
  result_t out_q;
  logic    out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beat_limit  <= RESET_BEAT_LIMIT;
      cfg_q.transfer_id <= RESET_ID;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BEAT_LIMIT: cfg_q.beat_limit  <= cfg_data_i;
        CFG_XFER_ID:    cfg_q.transfer_id <= cfg_data_i[ID_W-1:0];
        default:        cfg_q             <= cfg_q;
      endcase
    end
  end

  assign in_item.func          = s_axis_tuser;
  assign in_item.start_address = s_axis_tdata[31:0];
  assign in_item.xfer_bytes    = s_axis_tdata[52:32];
  assign in_item.source_data   = s_axis_tdata[116:53];
  assign in_item.response      = s_axis_tdata[118:117];

  abwm_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (s_axis_tvalid),
    .load_ready_o (s_axis_tready),
    .load_item_i  (in_item),
    .pop_i        (fire),
    .valid_o      (held_valid),
    .item_o       (held_item)
  );

  // The held transaction is processed once the output register can take a result.
  assign fire = held_valid && (!out_valid_q || m_axis_tready);

  abwm_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (held_item),
    .cfg_i     (cfg_q),
    .has_res_o (has_res),
    .res_o     (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && has_res) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && has_res) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.beat_last;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {1'b0, out_q.error_response, out_q.beat_strobe, out_q.beat_data,
                          out_q.burst_id, out_q.burst_len, out_q.burst_address,
                          out_q.addr_valid};

endmodule

@@ design/abwm_in_reg.sv @@
// ----------------------------------------------------------------------------
// Burst write master input register
// Holds one accepted transaction until the engine consumes it; refills in
// the same cycle it is consumed.
// ----------------------------------------------------------------------------
module abwm_in_reg
  import abwm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_valid_i,
  output logic  load_ready_o,
  input  item_t load_item_i,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign load_ready_o = !valid_q || pop_i;
  assign valid_o      = valid_q;
  assign item_o       = item_q;

  always_comb begin
    valid_d = valid_q;
    if (load_valid_i && load_ready_o) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_valid_i && load_ready_o) begin
      item_q <= load_item_i;
    end
  end

endmodule

@@ design/abwm_engine.sv @@
// ----------------------------------------------------------------------------
// Burst write master engine
// Transfer state and the single-pass logic that turns one transaction into
// at most one result: burst split, data realignment and byte strobes.
// ----------------------------------------------------------------------------
module abwm_engine
  import abwm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output logic    has_res_o,
  output result_t res_o
);

  logic [ADDR_WIDTH-1:0] next_addr_q, next_addr_d;
  logic [BEATS_W-1:0]    beats_left_q, beats_left_d;
  logic [LINES_W-1:0]    lines_left_q, lines_left_d;
  logic [OFF_W-1:0]      start_off_q, start_off_d;
  logic [OFF_W-1:0]      end_off_q, end_off_d;
  logic [LINES_W-1:0]    words_left_q, words_left_d;
  logic                  first_q, first_d;
  logic [DATA_W-1:0]     carry_q, carry_d;
  logic                  await_q, await_d;
  logic                  busy_q, busy_d;

  // Start command decode.
  logic [OFF_W-1:0]       off;
  logic [COUNT_WIDTH:0]   span;
  logic [COUNT_WIDTH:0]   words_rnd;
  logic [LINES_W-1:0]     lines_start;
  logic [LINES_W-1:0]     words_start;
  logic                   count_ok;

  // Burst sizing.
  logic [BEATS_W-1:0]      cap;
  logic [PAGE_LINES_W-1:0] page_lines;
  logic [PAGE_LINES_W-1:0] min_lp;
  logic [BEATS_W-1:0]      burst_beats;
  logic [BEATS_W-1:0]      beats_cur;

  // Beat data path.
  logic [DATA_W-1:0]       word;
  logic [OFF_W+2:0]        up_sh;
  logic [OFF_W+3:0]        dn_sh;
  logic [OFF_W-1:0]        lo;
  logic [OFF_W:0]          hi;
  logic [BUS_BYTES_N-1:0]  lo_mask;
  logic [BUS_BYTES_N:0]    hi_mask;

  assign off         = item_i.start_address[OFF_W-1:0];
  assign span        = (COUNT_WIDTH+1)'(off) + (COUNT_WIDTH+1)'(item_i.xfer_bytes);
  assign lines_start = LINES_W'(((span - 1'b1) >> OFF_W) + 1'b1);
  assign words_rnd   = (COUNT_WIDTH+1)'(item_i.xfer_bytes) + (COUNT_WIDTH+1)'(BUS_BYTES_N - 1);
  assign words_start = LINES_W'(words_rnd >> OFF_W);
  assign count_ok    = (item_i.xfer_bytes != '0) && (item_i.xfer_bytes <= MAX_COUNT);

  always_comb begin
    priority if (cfg_i.beat_limit == '0) begin
      cap = BEATS_W'(1);
    end else if (cfg_i.beat_limit > CFG_DATA_W'(MAX_BEATS)) begin
      cap = MAX_BEATS;
    end else begin
      cap = BEATS_W'(cfg_i.beat_limit);
    end
  end

  // Lines from here to the end of the page; never zero on a line-aligned address.
  assign page_lines  = PAGE_LINES - PAGE_LINES_W'(next_addr_q[PAGE_W-1:OFF_W]);
  assign min_lp      = (lines_left_q < LINES_W'(page_lines)) ?
                       PAGE_LINES_W'(lines_left_q) : page_lines;
  assign burst_beats = (PAGE_LINES_W'(cap) < min_lp) ? cap : BEATS_W'(min_lp);
  assign beats_cur   = (beats_left_q == '0) ? burst_beats : beats_left_q;

  assign word    = (words_left_q != '0) ? item_i.source_data : '0;
  assign up_sh   = {start_off_q, 3'b000};
  assign dn_sh   = (OFF_W+4)'(DATA_W) - (OFF_W+4)'(up_sh);
  assign lo      = first_q ? start_off_q : '0;
  assign hi      = ((lines_left_q == LINES_W'(1)) && (end_off_q != '0)) ?
                   (OFF_W+1)'(end_off_q) : (OFF_W+1)'(BUS_BYTES_N);
  assign lo_mask = {BUS_BYTES_N{1'b1}} << lo;
  assign hi_mask = ((BUS_BYTES_N+1)'(1) << hi) - (BUS_BYTES_N+1)'(1);

  always_comb begin
    next_addr_d  = next_addr_q;
    beats_left_d = beats_left_q;
    lines_left_d = lines_left_q;
    start_off_d  = start_off_q;
    end_off_d    = end_off_q;
    words_left_d = words_left_q;
    first_d      = first_q;
    carry_d      = carry_q;
    await_d      = await_q;
    busy_d       = busy_q;
    has_res_o    = 1'b0;
    res_o        = '0;
    res_o.status = ST_IGNORED;

    unique case (item_i.func)
      FUNC_START: begin
        if (!busy_q && count_ok) begin
          next_addr_d  = {item_i.start_address[ADDR_WIDTH-1:OFF_W], {OFF_W{1'b0}}};
          start_off_d  = off;
          end_off_d    = span[OFF_W-1:0];
          lines_left_d = lines_start;
          words_left_d = words_start;
          beats_left_d = '0;
          first_d      = 1'b1;
          carry_d      = '0;
          await_d      = 1'b0;
          busy_d       = 1'b1;
        end else begin
          has_res_o = 1'b1;
        end
      end
      FUNC_RESP: begin
        if (busy_q && await_q) begin
          await_d = 1'b0;
          if (item_i.response != RESP_OKAY) begin
            busy_d               = 1'b0;
            lines_left_d         = '0;
            beats_left_d         = '0;
            has_res_o            = 1'b1;
            res_o.status         = ST_ABORT;
            res_o.error_response = item_i.response;
          end else if (lines_left_q == '0) begin
            busy_d       = 1'b0;
            has_res_o    = 1'b1;
            res_o.status = ST_DONE;
          end
        end else begin
          has_res_o = 1'b1;
        end
      end
      FUNC_BEAT: begin
        has_res_o = 1'b1;
        if (busy_q && !await_q && (lines_left_q != '0)) begin
          res_o.status = ST_BEAT;
          if (beats_left_q == '0) begin
            res_o.addr_valid    = 1'b1;
            res_o.burst_address = next_addr_q;
            res_o.burst_len     = LEN_WIDTH'(burst_beats - 1'b1);
            res_o.burst_id      = cfg_i.transfer_id;
          end
          if (words_left_q != '0) begin
            words_left_d = words_left_q - 1'b1;
          end
          res_o.beat_data   = (word << up_sh) | carry_q;
          // High bytes of this word that did not fit move to the next beat.
          carry_d           = (start_off_q != '0) ? (word >> dn_sh) : '0;
          res_o.beat_strobe = lo_mask & hi_mask[BUS_BYTES_N-1:0];
          beats_left_d      = beats_cur - 1'b1;
          lines_left_d      = lines_left_q - 1'b1;
          next_addr_d       = next_addr_q + ADDR_WIDTH'(BUS_BYTES_N);
          first_d           = 1'b0;
          if (beats_cur == BEATS_W'(1)) begin
            res_o.beat_last = 1'b1;
            await_d         = 1'b1;
          end
        end
      end
      default: begin
        has_res_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_addr_q  <= '0;
      beats_left_q <= '0;
      lines_left_q <= '0;
      start_off_q  <= '0;
      end_off_q    <= '0;
      words_left_q <= '0;
      first_q      <= 1'b0;
      carry_q      <= '0;
      await_q      <= 1'b0;
      busy_q       <= 1'b0;
    end else if (fire_i) begin
      next_addr_q  <= next_addr_d;
      beats_left_q <= beats_left_d;
      lines_left_q <= lines_left_d;
      start_off_q  <= start_off_d;
      end_off_q    <= end_off_d;
      words_left_q <= words_left_d;
      first_q      <= first_d;
      carry_q      <= carry_d;
      await_q      <= await_d;
      busy_q       <= busy_d;
    end
  end

endmodule

@@ design/abwm_checker.sv @@
// ----------------------------------------------------------------------------
// Burst write master port checker
// Watches the result stream of the top level and is bound to it.
// ----------------------------------------------------------------------------
module abwm_checker
  import abwm_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast,
  input logic [1:0]            m_axis_tuser
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A status-only transaction carries no beat.
  a_status_no_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_BEAT) |->
      !m_axis_tlast && (m_axis_tdata[116:109] == '0) && !m_axis_tdata[0])
    else $error("status result carries beat fields");

  // Every beat writes at least one byte lane.
  a_beat_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_BEAT) |-> (m_axis_tdata[116:109] != '0))
    else $error("beat with empty strobe");

  // An abort always reports the failing response code.
  a_abort_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_ABORT) |-> (m_axis_tdata[118:117] != RESP_OKAY))
    else $error("abort without error response");

endmodule

bind axi_burst_write_master abwm_checker u_abwm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
